// ----- sv/dcsr_pkg.sv -----
// Package for the dense block to CSR pruner: shared constants, register
// indexes and the packed layout of one output record. No dependencies.
package dcsr_pkg;

    // Default sizes for the top-level parameters
    localparam int MAX_ORBITALS_DEF = 1024;
    localparam int MAX_KPOINTS_DEF  = 1024;
    localparam int VALUE_BITS_DEF   = 32;

    // Field widths of the stream items
    localparam int VALUE_W   = 32;
    localparam int IN_DATA_W = 2 * VALUE_W;
    localparam int INDEX_W   = 21;
    localparam int PTR_W     = 23;
    localparam int MAG_W     = 64;

    // Configuration register widths and indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_SIZE_W  = 11;
    localparam int CFG_SPIN_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_ORBITALS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KPOINTS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPIN      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd3;

    // Spin block counts that change the scan shape
    localparam logic [CFG_SPIN_W-1:0] SPIN_ONE  = 3'd1;
    localparam logic [CFG_SPIN_W-1:0] SPIN_FULL = 3'd4;

    // Saturation bound of the kept-entry count
    localparam logic [PTR_W-1:0] COUNT_LIMIT = 23'd4194304;

    // Record kinds carried on tuser
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_ROW_END = 1'b1;

    // Output tdata layout, entry_real in the lowest bits, padded to whole bytes
    localparam int OUT_USED_W = 2 * VALUE_W + 2 * INDEX_W + PTR_W + 1;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    typedef struct packed {
        logic [OUT_PAD_W-1:0] spare;
        logic                 matrix_done;
        logic [PTR_W-1:0]     row_pointer;
        logic [INDEX_W-1:0]   row_number;
        logic [INDEX_W-1:0]   column_number;
        logic [VALUE_W-1:0]   entry_imag;
        logic [VALUE_W-1:0]   entry_real;
    } rec_t;

endpackage

// ----- sv/dense_block_to_csr_pruner.sv -----
// Dense block to CSR pruner, top level: scan counters, magnitude pipeline,
// record staging and output register. Depends on dcsr_pkg.
//
// Usage: complex elements enter on the s_axis channel in row scan order
// (k-point, row spin, row orbital, column spin, column orbital), tdata holding
// value_real and value_imag. Each element whose squared magnitude is above
// threshold_squared leaves on m_axis as a kept-entry record (tuser = 0) with
// its column and row. After the last element of a row a row-end record
// (tuser = 1) carries the running kept count as the CSR row pointer, and
// matrix_done on the final row. tlast marks the last record of one element.
// Registers are written on the cfg channel, which is always ready.
// An accepted element passes through stage 1, stage 2 and stage 3 before its
// records reach m_axis. An element that gives a kept entry and a row end holds
// stage 3 until its entry record has been loaded into the single output register.
// Stages: input/counter stage, multiplier stage, compare/count stage, output.
// Reset clears the counters, the kept count, all stage valid bits and loads
// the register defaults (one orbital, one k-point, one spin block, zero
// threshold). When m_axis stalls, records hold in the output register and the
// stages behind it fill and then drop s_axis tready.
module dense_block_to_csr_pruner #(
    parameter int MAX_ORBITALS = dcsr_pkg::MAX_ORBITALS_DEF,
    parameter int MAX_KPOINTS  = dcsr_pkg::MAX_KPOINTS_DEF,
    parameter int VALUE_BITS   = dcsr_pkg::VALUE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Element requests
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // value_real [31:0], value_imag [63:32]
    input  logic [dcsr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // Record requests
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // entry_real [31:0], entry_imag [63:32], column_number [84:64],
    // row_number [105:85], row_pointer [128:106], matrix_done [129], zeros above
    output logic [dcsr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // record_kind [0]
    output logic [0:0]                         m_axis_tuser,
    output logic                               m_axis_tlast,
    // Configuration write requests
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dcsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dcsr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int VW     = dcsr_pkg::VALUE_W;
    localparam int IW     = dcsr_pkg::INDEX_W;
    localparam int PW     = dcsr_pkg::PTR_W;
    localparam int MW     = dcsr_pkg::MAG_W;
    localparam int SW     = dcsr_pkg::CFG_SIZE_W;
    localparam int SHIFT  = VW - VALUE_BITS;
    // Counter widths and clamped size widths
    localparam int ORB_W  = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;
    localparam int KP_W   = (MAX_KPOINTS > 1) ? $clog2(MAX_KPOINTS) : 1;
    localparam int NO_W   = $clog2(MAX_ORBITALS + 1);
    localparam int NK_W   = $clog2(MAX_KPOINTS + 1);
    localparam int OC_W   = ((SW > NO_W) ? SW : NO_W) + 1;
    localparam int KC_W   = ((SW > NK_W) ? SW : NK_W) + 1;

    // Configuration registers
    logic [SW-1:0]                   orb_cfg_reg;
    logic [SW-1:0]                   kp_cfg_reg;
    logic [dcsr_pkg::CFG_SPIN_W-1:0] spin_cfg_reg;
    logic [MW-1:0]                   thr_reg;

    // Scan counters
    logic [KP_W-1:0]  kp_reg, kp_next;
    logic             rs_reg, rs_next;
    logic [ORB_W-1:0] ro_reg, ro_next;
    logic             cs_reg, cs_next;
    logic [ORB_W-1:0] co_reg, co_next;
    logic [PW-1:0]    kept_reg, kept_next;

    // Stage 1: element and scan snapshot
    logic                 s1_v_reg;
    logic signed [VW-1:0] s1_re_reg, s1_im_reg;
    logic [IW-1:0]        s1_rfac_reg, s1_cfac_reg;
    logic [ORB_W-1:0]     s1_ro_reg, s1_co_reg;
    logic [NO_W-1:0]      s1_nou_reg;
    logic                 s1_end_reg, s1_done_reg;

    // Stage 2: squares and combined indexes
    logic                 s2_v_reg;
    logic signed [VW-1:0] s2_re_reg, s2_im_reg;
    logic [MW-1:0]        s2_sqr_reg, s2_sqi_reg;
    logic [IW-1:0]        s2_row_reg, s2_col_reg;
    logic                 s2_end_reg, s2_done_reg;

    // Stage 3: pending records
    logic             a_pend_reg, b_pend_reg;
    logic [VW-1:0]    s3_re_reg, s3_im_reg;
    logic [IW-1:0]    s3_row_reg, s3_col_reg;
    logic [PW-1:0]    s3_ptr_reg;
    logic             s3_done_reg;

    // Output register
    logic             out_v_reg;
    dcsr_pkg::rec_t   out_data_reg, out_data_next;
    logic             out_kind_reg, out_kind_next;
    logic             out_last_reg, out_last_next;

    // Handshake and scan decode signals
    logic             in_take, s2_take, s3_take, out_free, out_load;
    logic             s1_ready, s2_ready, s3_ready;
    logic [OC_W-1:0]  orb_ext;
    logic [KC_W-1:0]  kp_ext;
    logic [NO_W-1:0]  no_u;
    logic [NK_W-1:0]  nk;
    logic             nspin2, diag, is2;
    logic             col_last, row_last, kp_last, rs_wrap, cs_wrap, row_end, done;
    logic signed [VW-1:0] in_re_raw, in_im_raw, in_re, in_im;
    logic [IW-1:0]    kp_base;
    logic [VW-1:0]    abs_re, abs_im;
    logic [MW-1:0]    mag;
    logic             keep;
    logic [PW-1:0]    cnt_inc;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orb_cfg_reg  <= SW'(1);
            kp_cfg_reg   <= SW'(1);
            spin_cfg_reg <= dcsr_pkg::SPIN_ONE;
            thr_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dcsr_pkg::REG_ORBITALS:  orb_cfg_reg  <= cfg_data[SW-1:0];
                dcsr_pkg::REG_KPOINTS:   kp_cfg_reg   <= cfg_data[SW-1:0];
                dcsr_pkg::REG_SPIN:      spin_cfg_reg <= cfg_data[dcsr_pkg::CFG_SPIN_W-1:0];
                dcsr_pkg::REG_THRESHOLD: thr_reg      <= cfg_data;
                default:                 thr_reg      <= thr_reg;
            endcase
        end
    end

    // Pipeline handshakes: each stage advances when the one ahead frees up
    assign out_free = !out_v_reg || m_axis_tready;
    assign out_load = out_free && (a_pend_reg || b_pend_reg);
    assign s3_ready = !(a_pend_reg || b_pend_reg) || (out_free && !(a_pend_reg && b_pend_reg));
    assign s3_take  = s2_v_reg && s3_ready;
    assign s2_ready = !s2_v_reg || s3_ready;
    assign s2_take  = s1_v_reg && s2_ready;
    assign s1_ready = !s1_v_reg || s2_ready;
    assign s_axis_tready = s1_ready;
    assign in_take  = s_axis_tvalid && s1_ready;

    // Clamp sizes and decode the spin mode
    always_comb
    begin
        orb_ext = OC_W'(orb_cfg_reg);
        kp_ext  = KC_W'(kp_cfg_reg);
        if (orb_ext == '0)
            no_u = NO_W'(1);
        else if (orb_ext > OC_W'(MAX_ORBITALS))
            no_u = NO_W'(MAX_ORBITALS);
        else
            no_u = NO_W'(orb_ext);
        if (kp_ext == '0)
            nk = NK_W'(1);
        else if (kp_ext > KC_W'(MAX_KPOINTS))
            nk = NK_W'(MAX_KPOINTS);
        else
            nk = NK_W'(kp_ext);
        nspin2 = spin_cfg_reg > dcsr_pkg::SPIN_ONE;
        diag   = spin_cfg_reg < dcsr_pkg::SPIN_FULL;
    end

    // Advance the scan counters for the element being taken
    always_comb
    begin
        col_last = (OC_W'(co_reg) + OC_W'(1)) >= OC_W'(no_u);
        row_last = (OC_W'(ro_reg) + OC_W'(1)) >= OC_W'(no_u);
        kp_last  = (KC_W'(kp_reg) + KC_W'(1)) >= KC_W'(nk);
        rs_wrap  = !nspin2 || rs_reg;
        cs_wrap  = !nspin2 || cs_reg;
        row_end  = col_last && (diag || cs_wrap);
        is2      = diag ? rs_reg : cs_reg;
        done     = 1'b0;
        kp_next  = kp_reg;
        rs_next  = rs_reg;
        ro_next  = ro_reg;
        cs_next  = cs_reg;
        co_next  = co_reg;
        if (!row_end)
        begin
            if (col_last)
            begin
                co_next = '0;
                cs_next = !cs_reg;
            end
            else
            begin
                co_next = co_reg + ORB_W'(1);
            end
        end
        else
        begin
            co_next = '0;
            if (row_last)
            begin
                ro_next = '0;
                if (rs_wrap)
                begin
                    rs_next = 1'b0;
                    if (kp_last)
                    begin
                        kp_next = '0;
                        done    = 1'b1;
                    end
                    else
                    begin
                        kp_next = kp_reg + KP_W'(1);
                    end
                end
                else
                begin
                    rs_next = 1'b1;
                end
            end
            else
            begin
                ro_next = ro_reg + ORB_W'(1);
            end
            cs_next = diag ? rs_next : 1'b0;
        end
    end

    // Sign-extend the element from its significant width, form index bases
    always_comb
    begin
        in_re_raw = s_axis_tdata[VW-1:0] << SHIFT;
        in_im_raw = s_axis_tdata[2*VW-1:VW] << SHIFT;
        in_re     = in_re_raw >>> SHIFT;
        in_im     = in_im_raw >>> SHIFT;
        kp_base   = nspin2 ? (IW'(kp_reg) << 1) : IW'(kp_reg);
    end

    // Hold scan counters and stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= '0;
            rs_reg     <= 1'b0;
            ro_reg     <= '0;
            cs_reg     <= 1'b0;
            co_reg     <= '0;
            kept_reg   <= '0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            a_pend_reg <= 1'b0;
            b_pend_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                kp_reg <= kp_next;
                rs_reg <= rs_next;
                ro_reg <= ro_next;
                cs_reg <= cs_next;
                co_reg <= co_next;
            end
            if (s1_ready)
                s1_v_reg <= s_axis_tvalid;
            if (s2_ready)
                s2_v_reg <= s1_v_reg;
            if (s3_take)
            begin
                kept_reg   <= kept_next;
                a_pend_reg <= keep;
                b_pend_reg <= s2_end_reg;
            end
            else if (out_load)
            begin
                if (a_pend_reg)
                    a_pend_reg <= 1'b0;
                else
                    b_pend_reg <= 1'b0;
            end
            else if (!s2_v_reg)
            begin
                a_pend_reg <= a_pend_reg;
            end
            if (out_load)
                out_v_reg <= 1'b1;
            else if (m_axis_tready)
                out_v_reg <= 1'b0;
        end
    end

    // Stage 1: capture the element and its scan position
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_re_reg   <= in_re;
            s1_im_reg   <= in_im;
            s1_rfac_reg <= kp_base + IW'(rs_reg);
            s1_cfac_reg <= kp_base + IW'(is2);
            s1_ro_reg   <= ro_reg;
            s1_co_reg   <= co_reg;
            s1_nou_reg  <= no_u;
            s1_end_reg  <= row_end;
            s1_done_reg <= done;
        end
    end

    // Stage 2: square both parts, scale the index bases by the block size
    always_comb
    begin
        abs_re = s1_re_reg[VW-1] ? (VW'(0) - VW'(s1_re_reg)) : VW'(s1_re_reg);
        abs_im = s1_im_reg[VW-1] ? (VW'(0) - VW'(s1_im_reg)) : VW'(s1_im_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s2_take)
        begin
            s2_re_reg   <= s1_re_reg;
            s2_im_reg   <= s1_im_reg;
            s2_sqr_reg  <= MW'(abs_re) * MW'(abs_re);
            s2_sqi_reg  <= MW'(abs_im) * MW'(abs_im);
            s2_row_reg  <= IW'(s1_rfac_reg * IW'(s1_nou_reg)) + IW'(s1_ro_reg);
            s2_col_reg  <= IW'(s1_cfac_reg * IW'(s1_nou_reg)) + IW'(s1_co_reg);
            s2_end_reg  <= s1_end_reg;
            s2_done_reg <= s1_done_reg;
        end
    end

    // Stage 3: compare against the threshold, update the kept count
    always_comb
    begin
        mag     = s2_sqr_reg + s2_sqi_reg;
        keep    = mag > thr_reg;
        cnt_inc = (keep && (kept_reg < dcsr_pkg::COUNT_LIMIT)) ? kept_reg + PW'(1) : kept_reg;
        kept_next = (s2_end_reg && s2_done_reg) ? '0 : cnt_inc;
    end

    always_ff @(posedge clk)
    begin
        if (s3_take)
        begin
            s3_re_reg   <= VW'(s2_re_reg);
            s3_im_reg   <= VW'(s2_im_reg);
            s3_row_reg  <= s2_row_reg;
            s3_col_reg  <= s2_col_reg;
            s3_ptr_reg  <= cnt_inc;
            s3_done_reg <= s2_done_reg;
        end
    end

    // Build the next record: kept entry first, then the row end
    always_comb
    begin
        out_data_next       = '0;
        out_data_next.row_number = s3_row_reg;
        if (a_pend_reg)
        begin
            out_data_next.entry_real    = s3_re_reg;
            out_data_next.entry_imag    = s3_im_reg;
            out_data_next.column_number = s3_col_reg;
            out_kind_next = dcsr_pkg::KIND_ENTRY;
            out_last_next = !b_pend_reg;
        end
        else
        begin
            out_data_next.row_pointer = s3_ptr_reg;
            out_data_next.matrix_done = s3_done_reg;
            out_kind_next = dcsr_pkg::KIND_ROW_END;
            out_last_next = 1'b1;
        end
    end

    // Output register: load a record when the slot is free
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
            out_kind_reg <= out_kind_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_axis_tvalid   = out_v_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_kind_reg;
    assign m_axis_tlast    = out_last_reg;

endmodule

// ----- test/tb_dense_block_to_csr_pruner.sv -----
// Self-checking testbench for dense_block_to_csr_pruner: directed and random
// element streams, checked record by record against a scan-order predictor.
// Depends on dcsr_pkg and the pruner top level.
`timescale 1ns / 100ps

module tb_dense_block_to_csr_pruner;

    localparam int VALUE_W     = dcsr_pkg::VALUE_W;
    localparam int MAG_W       = dcsr_pkg::MAG_W;
    localparam int INDEX_W     = dcsr_pkg::INDEX_W;
    localparam int PTR_W       = dcsr_pkg::PTR_W;
    localparam int IN_DATA_W   = dcsr_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = dcsr_pkg::OUT_DATA_W;
    localparam int CFG_INDEX_W = dcsr_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = dcsr_pkg::CFG_DATA_W;
    localparam int CFG_SIZE_W  = dcsr_pkg::CFG_SIZE_W;
    localparam int CFG_SPIN_W  = dcsr_pkg::CFG_SPIN_W;

    localparam int RANDOM_ITEMS  = 650;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [VALUE_W-1:0] VALUE_MAX   = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_MIN   = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VALUE_ONE   = 32'h0000_0001;
    localparam logic [VALUE_W-1:0] VALUE_NEG1  = 32'hFFFF_FFFF;
    localparam logic [MAG_W-1:0]   MAG_HALF    = 64'h8000_0000_0000_0000;
    localparam logic [MAG_W-1:0]   MAG_ALL     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [MAG_W-1:0]   MAG_UNITY   = 64'h0000_0100_0000_0000;

    // One record as it should leave the block
    typedef struct packed {
        logic           kind;
        dcsr_pkg::rec_t body;
        logic           tail;
    } csr_record_t;

    // Scan-order predictor plus the records still owed by the block
    class csr_record_tracker;
        logic [CFG_SIZE_W-1:0] orbitals;
        logic [CFG_SIZE_W-1:0] kpoints;
        logic [CFG_SPIN_W-1:0] spin_blocks;
        logic [MAG_W-1:0]      threshold;
        int unsigned kpoint_idx;
        int unsigned row_spin;
        int unsigned row_orbital;
        int unsigned col_spin;
        int unsigned col_orbital;
        int unsigned kept_count;
        csr_record_t pending_records[$];
        int error_count;
        int record_count;

        function new();
            orbitals    = CFG_SIZE_W'(1);
            kpoints     = CFG_SIZE_W'(1);
            spin_blocks = dcsr_pkg::SPIN_ONE;
            threshold   = '0;
            kpoint_idx  = 0;
            row_spin    = 0;
            row_orbital = 0;
            col_spin    = 0;
            col_orbital = 0;
            kept_count  = 0;
            error_count = 0;
            record_count = 0;
        endfunction

        function int pending();
            return pending_records.size();
        endfunction

        function void report(string msg);
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        // Squared magnitude of a Q12.20 pair, Q24.40
        function logic [MAG_W-1:0] magnitude(logic [VALUE_W-1:0] re, logic [VALUE_W-1:0] im);
            logic [MAG_W-1:0] ar;
            logic [MAG_W-1:0] ai;
            ar = {32'd0, (re[VALUE_W-1] ? -re : re)};
            ai = {32'd0, (im[VALUE_W-1] ? -im : im)};
            return ar * ar + ai * ai;
        endfunction

        function void note_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            unique case (index)
                dcsr_pkg::REG_ORBITALS:  orbitals    = value[CFG_SIZE_W-1:0];
                dcsr_pkg::REG_KPOINTS:   kpoints     = value[CFG_SIZE_W-1:0];
                dcsr_pkg::REG_SPIN:      spin_blocks = value[CFG_SPIN_W-1:0];
                dcsr_pkg::REG_THRESHOLD: threshold   = value;
                default: ;
            endcase
        endfunction

        // Predict the records of one accepted element and advance the scan
        function void note_element(logic [VALUE_W-1:0] re, logic [VALUE_W-1:0] im);
            int unsigned orb;
            int unsigned kcount;
            int unsigned nspin;
            int unsigned col_spin_sel;
            int unsigned row_idx;
            int unsigned col_idx;
            bit diag;
            bit kept;
            bit col_last;
            bit row_end;
            bit done;
            csr_record_t entry_rec;
            csr_record_t end_rec;

            orb = 32'(orbitals);
            if (orb < 1) orb = 1;
            if (orb > dcsr_pkg::MAX_ORBITALS_DEF) orb = dcsr_pkg::MAX_ORBITALS_DEF;
            kcount = 32'(kpoints);
            if (kcount < 1) kcount = 1;
            if (kcount > dcsr_pkg::MAX_KPOINTS_DEF) kcount = dcsr_pkg::MAX_KPOINTS_DEF;
            nspin = (spin_blocks > dcsr_pkg::SPIN_ONE) ? 2 : 1;
            diag  = (spin_blocks < dcsr_pkg::SPIN_FULL);

            // In diagonal mode the column spin follows the row spin
            col_spin_sel = diag ? row_spin : col_spin;
            row_idx = (kpoint_idx * nspin + row_spin) * orb + row_orbital;
            col_idx = (kpoint_idx * nspin + col_spin_sel) * orb + col_orbital;

            kept = (magnitude(re, im) > threshold);
            entry_rec = '0;
            if (kept)
            begin
                entry_rec.kind               = dcsr_pkg::KIND_ENTRY;
                entry_rec.body.entry_real    = re;
                entry_rec.body.entry_imag    = im;
                entry_rec.body.column_number = col_idx[INDEX_W-1:0];
                entry_rec.body.row_number    = row_idx[INDEX_W-1:0];
                if (kept_count < dcsr_pkg::COUNT_LIMIT)
                    kept_count++;
            end

            col_last = (col_orbital + 1 >= orb);
            row_end  = col_last && (diag || col_spin + 1 >= nspin);
            done     = 1'b0;

            // Advance the column, or close the row and move the row counters
            if (!row_end)
            begin
                if (col_last)
                begin
                    col_orbital = 0;
                    col_spin    = (col_spin + 1) & 1;
                end
                else
                begin
                    col_orbital++;
                end
            end
            else
            begin
                col_orbital = 0;
                if (row_orbital + 1 >= orb)
                begin
                    row_orbital = 0;
                    if (row_spin + 1 >= nspin)
                    begin
                        row_spin = 0;
                        if (kpoint_idx + 1 >= kcount)
                        begin
                            kpoint_idx = 0;
                            done = 1'b1;
                        end
                        else
                        begin
                            kpoint_idx++;
                        end
                    end
                    else
                    begin
                        row_spin = (row_spin + 1) & 1;
                    end
                end
                else
                begin
                    row_orbital++;
                end
                col_spin = diag ? row_spin : 0;
            end

            end_rec = '0;
            if (row_end)
            begin
                end_rec.kind             = dcsr_pkg::KIND_ROW_END;
                end_rec.body.row_number  = row_idx[INDEX_W-1:0];
                end_rec.body.row_pointer = kept_count[PTR_W-1:0];
                end_rec.body.matrix_done = done;
                end_rec.tail             = 1'b1;
                if (done)
                    kept_count = 0;
            end

            if (kept)
            begin
                entry_rec.tail = !row_end;
                pending_records.push_back(entry_rec);
            end
            if (row_end)
                pending_records.push_back(end_rec);
        endfunction

        // Compare one accepted record with the oldest one owed
        function void check_record(logic [OUT_DATA_W-1:0] data, logic kind, logic tail);
            csr_record_t want;
            dcsr_pkg::rec_t got;
            string bad;

            record_count++;
            if (pending_records.size() == 0)
            begin
                report($sformatf("%0t: record %0d with none pending: kind %0b last %0b data %h",
                                 $time, record_count, kind, tail, data));
                return;
            end
            want = pending_records.pop_front();
            got  = data;
            bad  = "";
            if (want.kind !== kind)                              bad = {bad, " kind"};
            if (want.tail !== tail)                              bad = {bad, " last"};
            if (want.body.entry_real !== got.entry_real)         bad = {bad, " entry_real"};
            if (want.body.entry_imag !== got.entry_imag)         bad = {bad, " entry_imag"};
            if (want.body.column_number !== got.column_number)   bad = {bad, " column"};
            if (want.body.row_number !== got.row_number)         bad = {bad, " row"};
            if (want.body.row_pointer !== got.row_pointer)       bad = {bad, " row_pointer"};
            if (want.body.matrix_done !== got.matrix_done)       bad = {bad, " matrix_done"};
            if (want.body.spare !== got.spare)                   bad = {bad, " padding"};
            if (bad != "")
                report($sformatf({"%0t: record %0d mismatch in%s\n",
                                  "  expected kind %0b re %h im %h col %0d row %0d ptr %0d",
                                  " done %0b last %0b\n",
                                  "  actual   kind %0b re %h im %h col %0d row %0d ptr %0d",
                                  " done %0b last %0b pad %h"},
                                 $time, record_count, bad,
                                 want.kind, want.body.entry_real, want.body.entry_imag,
                                 want.body.column_number, want.body.row_number,
                                 want.body.row_pointer, want.body.matrix_done, want.tail,
                                 kind, got.entry_real, got.entry_imag, got.column_number,
                                 got.row_number, got.row_pointer, got.matrix_done, tail,
                                 got.spare));
        endfunction
    endclass

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic [0:0]              m_axis_tuser;
    logic                    m_axis_tlast;
    logic                    cfg_valid     = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0]   cfg_data      = '0;

    csr_record_tracker tracker = new();

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left   = 0;
    bit hold_served = 1'b0;
    logic hold_request = 1'b0;

    dense_block_to_csr_pruner #(
        .MAX_ORBITALS (dcsr_pkg::MAX_ORBITALS_DEF),
        .MAX_KPOINTS  (dcsr_pkg::MAX_KPOINTS_DEF),
        .VALUE_BITS   (dcsr_pkg::VALUE_BITS_DEF)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Check record requests; stall at random, hold off once for a long stretch
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            tracker.check_record(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
        if (hold_request && !hold_served)
        begin
            hold_left   = HOLD_CYCLES;
            hold_served = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Offer one element request, idling first at random; tvalid stays high after
    task automatic send_element(logic [VALUE_W-1:0] re, logic [VALUE_W-1:0] im);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {im, re};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_element(re, im);
    endtask

    // Write all four registers back to back, then drop the request
    task automatic apply_settings(logic [CFG_SIZE_W-1:0] orbitals,
                                  logic [CFG_SIZE_W-1:0] kpoints,
                                  logic [CFG_SPIN_W-1:0] spin,
                                  logic [MAG_W-1:0] threshold);
        logic [CFG_INDEX_W-1:0] indexes [4];
        logic [CFG_DATA_W-1:0]  values  [4];
        indexes = '{dcsr_pkg::REG_ORBITALS, dcsr_pkg::REG_KPOINTS,
                    dcsr_pkg::REG_SPIN, dcsr_pkg::REG_THRESHOLD};
        values  = '{CFG_DATA_W'(orbitals), CFG_DATA_W'(kpoints), CFG_DATA_W'(spin), threshold};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= indexes[i];
            cfg_data  <= values[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            tracker.note_register(indexes[i], values[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, wait for every owed record, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Element part with a spread of scales and the extremes
    function automatic logic [VALUE_W-1:0] random_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = VALUE_MIN;
            1: v = VALUE_MAX;
            2: v = '0;
            3: v = $urandom_range(0, 1) ? VALUE_NEG1 : VALUE_ONE;
            default:
            begin
                v = $urandom;
                v = v >>> $urandom_range(0, 30);
            end
        endcase
        return v;
    endfunction

    initial
    begin
        int random_sent;
        int phase_len;
        bit pressure_done;
        logic [CFG_SIZE_W-1:0] orbitals;
        logic [CFG_SIZE_W-1:0] kpoints;
        logic [CFG_SPIN_W-1:0] spin;
        logic [MAG_W-1:0]      threshold;

        random_sent   = 0;
        pressure_done = 1'b0;
        tx_idle_pct   = 33;
        rx_idle_pct   = 64;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sizes: every element is a whole matrix, zero threshold
        send_element('0, '0);
        send_element(VALUE_ONE, '0);
        send_element(VALUE_MAX, VALUE_MAX);
        send_element(VALUE_MIN, VALUE_MIN);
        send_element(VALUE_NEG1, '0);
        send_element('0, VALUE_MIN);
        drain();

        // Full spin blocks, threshold just below the largest magnitude; stop mid-row
        apply_settings(11'd2, 11'd2, dcsr_pkg::SPIN_FULL, MAG_HALF - 1);
        send_element(VALUE_MIN, VALUE_MIN);
        send_element(VALUE_MIN, VALUE_MAX);
        send_element('0, '0);
        send_element(VALUE_MIN, VALUE_MIN);
        send_element(VALUE_ONE, VALUE_ONE);
        drain();

        // Zero sizes clamp up, oversized k-points clamp down, zero spin acts as one
        apply_settings(11'd0, 11'd2047, 3'd0, MAG_HALF);
        send_element(VALUE_MIN, VALUE_MIN);
        send_element(VALUE_MAX, VALUE_MAX);
        send_element(VALUE_MIN, VALUE_MIN);
        drain();

        // Oversized orbitals, spin above four, nothing passes the top threshold
        apply_settings(11'd2047, 11'd0, 3'd7, MAG_ALL);
        send_element(VALUE_MIN, VALUE_MIN);
        send_element(VALUE_MAX, VALUE_NEG1);
        drain();

        // Two diagonal spin rows, threshold at one squared
        apply_settings(11'd3, 11'd1, 3'd2, MAG_UNITY);
        send_element(32'h0010_0000, '0);
        send_element(32'h0010_0000, VALUE_ONE);
        send_element(32'hFFF0_0000, '0);
        send_element('0, VALUE_MAX);
        send_element(32'd5, 32'd5);
        send_element(VALUE_MIN, 32'd3);
        drain();

        apply_settings(11'd1, 11'd2, 3'd5, '0);
        send_element('0, '0);
        send_element('0, VALUE_ONE);
        send_element(32'd2, 32'hFFFF_FFFE);
        drain();

        // Random phases, each with fresh settings and the scan left where it was
        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent >= 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (random_sent >= RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 64;
                rx_idle_pct = 33;
            end

            case ($urandom_range(0, 9))
                0:       orbitals = 11'd0;
                1:       orbitals = 11'd1024;
                2:       orbitals = $urandom_range(0, 1) ? 11'd2047 : 11'($urandom);
                default: orbitals = 11'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 9))
                0:       kpoints = 11'd0;
                1:       kpoints = 11'd1024;
                2:       kpoints = $urandom_range(0, 1) ? 11'd2047 : 11'($urandom);
                default: kpoints = 11'($urandom_range(1, 3));
            endcase
            spin = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 9))
                0:       threshold = '0;
                1:       threshold = MAG_ALL;
                2:       threshold = MAG_HALF;
                3:       threshold = MAG_HALF - 1;
                4:       threshold = {$urandom, $urandom} >> $urandom_range(0, 63);
                default: threshold = tracker.magnitude(random_value(), random_value());
            endcase
            apply_settings(orbitals, kpoints, spin, threshold);

            phase_len = $urandom_range(15, 45);
            if (!pressure_done && tx_idle_pct == 0)
            begin
                // Hold the receiver off while elements keep coming
                hold_request <= 1'b1;
                pressure_done = 1'b1;
                phase_len = 60;
            end
            repeat (phase_len) send_element(random_value(), random_value());
            random_sent += phase_len;
            drain();
        end

        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (tracker.error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // End the run if the stream hangs
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/dcsr_pkg.sv
sv/dense_block_to_csr_pruner.sv
test/tb_dense_block_to_csr_pruner.sv
